// ----- hdl/sample_stream_statistics_macros.svh -----
// assertion helpers shared by the statistics block
`ifndef SAMPLE_STREAM_STATISTICS_MACROS_SVH
`define SAMPLE_STREAM_STATISTICS_MACROS_SVH

// same-cycle implication, checked out of reset
`define SSS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/sss_pkg.sv -----
package sss_pkg;

  // saturation limits of the counters, indices and sum
  localparam int unsigned CNT_MAX = 32'h1F_FFFF;
  localparam int unsigned IDX_MAX = 32'h0F_FFFF;
  localparam int unsigned SUM_MAX = 32'h0FFF_FFFF;

  // default sequence length cap
  localparam int unsigned MAX_SAMPLES_DEF = 1048576;

  // reset value of the near-zero limit
  localparam logic [7:0] NEAR_ZERO_RST = 8'd2;

  // clip levels
  localparam logic signed [7:0] CLIP_HI = 8'sd127;
  localparam logic signed [7:0] CLIP_LO = -8'sd128;

  // depth of the queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic signed [7:0] sample;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] min_value;
    logic signed [7:0] max_value;
    logic [27:0]       abs_sum;
    logic [20:0]       near_zero_count;
    logic [20:0]       clipped_count;
    logic [20:0]       sample_total;
    logic signed [7:0] run_value;
    logic [19:0]       run_start;
    logic [19:0]       run_end;
  } out_item_t;

  // classified sample as held in the queue
  typedef struct packed {
    logic signed [7:0] sample;
    logic [7:0]        mag;
    logic              near_zero;
    logic              clipped;
    logic              last;
  } cls_item_t;

  // front to back link
  typedef struct packed {
    logic      valid;
    cls_item_t item;
  } fe_link_t;

endpackage

// ----- hdl/sample_stream_statistics.sv -----
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+---------------------------------
// in_      | input     | in_valid / in_ready   | in_data   (sample, last)
// out_     | output    | out_valid / out_ready | out_data  (one result per sequence)
// cfg_     | input     | cfg_valid / cfg_ready | cfg_data  (near-zero limit)
//
// one sample per cycle sustained while no last sample waits for an untaken result;
// a sample is held in the queue before the statistics update, which also loads a last
// sample's result onto out_; throughput is set by that update fed from a two-entry queue
// rst_n clears all statistics, the queue and the result slot; the limit returns to 2
// a last sample waits in the queue while an earlier result is still untaken
// once the queue holds two samples in_ready drops until one moves on

module sample_stream_statistics #(
  parameter int unsigned MAX_SAMPLES = sss_pkg::MAX_SAMPLES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sss_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sss_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);

  sss_pkg::fe_link_t link;
  logic              be_ready;

  // accept and classify
  sss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .link      (link),
    .be_ready  (be_ready)
  );

  // statistics and result
  sss_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .link      (link),
    .be_ready  (be_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- hdl/sss_front.sv -----
`include "sample_stream_statistics_macros.svh"

module sss_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sss_pkg::in_item_t in_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data,
  output sss_pkg::fe_link_t link,
  input  logic              be_ready
);

  localparam logic [sss_pkg::Q_CW-1:0] Q_CW_FULL = sss_pkg::Q_CW'(sss_pkg::Q_DEPTH);
  localparam logic [sss_pkg::Q_AW-1:0] Q_LAST    = sss_pkg::Q_AW'(sss_pkg::Q_DEPTH - 1);

  logic [7:0]                limit_r;
  logic [7:0]                limit_nxt;
  sss_pkg::cls_item_t        q_mem [sss_pkg::Q_DEPTH];
  logic [sss_pkg::Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [sss_pkg::Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [sss_pkg::Q_CW-1:0]  cnt_r, cnt_nxt;
  sss_pkg::cls_item_t        cls;
  logic                      q_valid;
  logic                      push;
  logic                      pop;

  // configuration register, always writable
  assign cfg_ready = 1'b1;
  assign limit_nxt = (cfg_valid && cfg_ready) ? cfg_data : limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= sss_pkg::NEAR_ZERO_RST;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  // classify the incoming sample
  always_comb begin
    cls.sample    = in_data.sample;
    cls.mag       = in_data.sample[7] ? (~in_data.sample + 8'd1) : in_data.sample;
    cls.near_zero = (cls.mag <= limit_r);
    cls.clipped   = (in_data.sample == sss_pkg::CLIP_HI) ||
                    (in_data.sample == sss_pkg::CLIP_LO);
    cls.last      = in_data.last;
  end

  // queue control
  assign in_ready = (cnt_r != Q_CW_FULL);
  assign q_valid  = (cnt_r != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && be_ready;
  assign link     = {q_valid, q_mem[rd_ptr_r]};

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cls;
    end
  end

  `SSS_ASSERT_IMPL(a_q_bound, 1'b1, cnt_r <= Q_CW_FULL, "queue fill beyond depth")
  `SSS_ASSERT_NEXT(a_q_grow, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "queue fill skipped")

endmodule

// ----- hdl/sss_back.sv -----
`include "sample_stream_statistics_macros.svh"

module sss_back #(
  parameter int unsigned MAX_SAMPLES = sss_pkg::MAX_SAMPLES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sss_pkg::fe_link_t  link,
  output logic               be_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output sss_pkg::out_item_t out_data
);

  localparam logic [20:0] CAP = 21'((MAX_SAMPLES < sss_pkg::CNT_MAX) ?
                                    MAX_SAMPLES : sss_pkg::CNT_MAX);
  localparam logic [20:0] CNT_CAP = 21'(sss_pkg::CNT_MAX);
  localparam logic [19:0] IDX_CAP = 20'(sss_pkg::IDX_MAX);
  localparam logic [27:0] SUM_CAP = 28'(sss_pkg::SUM_MAX);

  logic [20:0]        count_r, count_nxt;
  logic signed [7:0]  min_r, min_nxt;
  logic signed [7:0]  max_r, max_nxt;
  logic [27:0]        abs_sum_r, abs_sum_nxt;
  logic [20:0]        nz_r, nz_nxt;
  logic [20:0]        clip_r, clip_nxt;
  logic signed [7:0]  prev_r, prev_nxt;
  logic [19:0]        cur_start_r, cur_start_nxt;
  logic [19:0]        cur_len_r, cur_len_nxt;
  logic [19:0]        best_start_r, best_start_nxt;
  logic [19:0]        best_len_r, best_len_nxt;
  logic [19:0]        best_end_r, best_end_nxt;
  logic signed [7:0]  best_val_r, best_val_nxt;
  logic               out_valid_r, out_valid_nxt;
  sss_pkg::out_item_t out_data_r, out_data_nxt;

  sss_pkg::cls_item_t it;
  logic               pop;
  logic               first;
  logic [19:0]        idx;
  logic [28:0]        sum_w;
  logic [20:0]        end_w;

  // a last sample needs a free output slot, others never wait
  assign it       = link.item;
  assign be_ready = !it.last || !out_valid_r || out_ready;
  assign pop      = link.valid && be_ready;

  assign first = (count_r == '0);
  assign idx   = (count_r > 21'(IDX_CAP)) ? IDX_CAP : count_r[19:0];
  assign sum_w = {1'b0, abs_sum_r} + 29'(it.mag);

  // statistics update
  always_comb begin
    count_nxt      = count_r;
    min_nxt        = min_r;
    max_nxt        = max_r;
    abs_sum_nxt    = abs_sum_r;
    nz_nxt         = nz_r;
    clip_nxt       = clip_r;
    prev_nxt       = prev_r;
    cur_start_nxt  = cur_start_r;
    cur_len_nxt    = cur_len_r;
    best_start_nxt = best_start_r;
    best_len_nxt   = best_len_r;
    best_end_nxt   = best_end_r;
    best_val_nxt   = best_val_r;
    end_w          = '0;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (pop) begin
      // extremes and longest equal run
      if (first) begin
        min_nxt        = it.sample;
        max_nxt        = it.sample;
        best_val_nxt   = it.sample;
        best_start_nxt = '0;
        best_len_nxt   = '0;
        best_end_nxt   = '0;
        cur_start_nxt  = '0;
        cur_len_nxt    = '0;
      end else begin
        if (it.sample < min_r) begin
          min_nxt = it.sample;
        end
        if (it.sample > max_r) begin
          max_nxt = it.sample;
        end
        if (it.sample == prev_r) begin
          cur_len_nxt = (cur_len_r < IDX_CAP) ? cur_len_r + 1'b1 : IDX_CAP;
          if (cur_len_nxt > best_len_r) begin
            end_w          = {1'b0, cur_start_r} + {1'b0, cur_len_nxt};
            best_len_nxt   = cur_len_nxt;
            best_start_nxt = cur_start_r;
            best_val_nxt   = it.sample;
            best_end_nxt   = end_w[20] ? IDX_CAP : end_w[19:0];
          end
        end else begin
          cur_start_nxt = idx;
          cur_len_nxt   = '0;
        end
      end

      // saturating sums and tallies
      abs_sum_nxt = sum_w[28] ? SUM_CAP : sum_w[27:0];
      if (it.near_zero) begin
        nz_nxt = (nz_r < CNT_CAP) ? nz_r + 1'b1 : CNT_CAP;
      end
      if (it.clipped) begin
        clip_nxt = (clip_r < CNT_CAP) ? clip_r + 1'b1 : CNT_CAP;
      end
      prev_nxt  = it.sample;
      count_nxt = (count_r < CAP) ? count_r + 1'b1 : CAP;

      // end of sequence: load the result and clear
      if (it.last) begin
        out_valid_nxt                = 1'b1;
        out_data_nxt.min_value       = min_nxt;
        out_data_nxt.max_value       = max_nxt;
        out_data_nxt.abs_sum         = abs_sum_nxt;
        out_data_nxt.near_zero_count = nz_nxt;
        out_data_nxt.clipped_count   = clip_nxt;
        out_data_nxt.sample_total    = count_nxt;
        out_data_nxt.run_value       = best_val_nxt;
        out_data_nxt.run_start       = best_start_nxt;
        out_data_nxt.run_end         = best_end_nxt;
        count_nxt      = '0;
        min_nxt        = '0;
        max_nxt        = '0;
        abs_sum_nxt    = '0;
        nz_nxt         = '0;
        clip_nxt       = '0;
        prev_nxt       = '0;
        cur_start_nxt  = '0;
        cur_len_nxt    = '0;
        best_start_nxt = '0;
        best_len_nxt   = '0;
        best_end_nxt   = '0;
        best_val_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      min_r        <= '0;
      max_r        <= '0;
      abs_sum_r    <= '0;
      nz_r         <= '0;
      clip_r       <= '0;
      prev_r       <= '0;
      cur_start_r  <= '0;
      cur_len_r    <= '0;
      best_start_r <= '0;
      best_len_r   <= '0;
      best_end_r   <= '0;
      best_val_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      min_r        <= min_nxt;
      max_r        <= max_nxt;
      abs_sum_r    <= abs_sum_nxt;
      nz_r         <= nz_nxt;
      clip_r       <= clip_nxt;
      prev_r       <= prev_nxt;
      cur_start_r  <= cur_start_nxt;
      cur_len_r    <= cur_len_nxt;
      best_start_r <= best_start_nxt;
      best_len_r   <= best_len_nxt;
      best_end_r   <= best_end_nxt;
      best_val_r   <= best_val_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SSS_ASSERT_IMPL(a_min_max, count_r != '0, min_r <= max_r, "running minimum above maximum")
  `SSS_ASSERT_IMPL(a_best_run, 1'b1, best_len_r >= cur_len_r, "current run longer than best")
  `SSS_ASSERT_IMPL(a_run_span, 1'b1, best_end_r >= best_start_r, "best run ends before it starts")
  `SSS_ASSERT_NEXT(a_clear, pop && it.last, count_r == '0 && out_valid_r, "sequence not closed")

endmodule

// ----- test/sample_stream_statistics_tb.sv -----
`timescale 1ns / 100ps

module sample_stream_statistics_tb;

  // tracks the statistics of the sequence in progress and queues each finished result
  class stats_scoreboard;
    logic [7:0]         near_limit;
    int unsigned        seen;
    int unsigned        abs_total;
    int unsigned        near_tally;
    int unsigned        clip_tally;
    int unsigned        run_first;
    int unsigned        run_len;
    int unsigned        best_first;
    int unsigned        best_len;
    logic signed [7:0]  lo;
    logic signed [7:0]  hi;
    logic signed [7:0]  prev;
    logic signed [7:0]  best_val;
    sss_pkg::out_item_t expected_stats[$];
    int unsigned        errors;

    function new();
      near_limit = sss_pkg::NEAR_ZERO_RST;
      errors = 0;
      restart();
    endfunction

    function void restart();
      seen = 0;
      abs_total = 0;
      near_tally = 0;
      clip_tally = 0;
      run_first = 0;
      run_len = 0;
      best_first = 0;
      best_len = 0;
      lo = '0;
      hi = '0;
      prev = '0;
      best_val = '0;
    endfunction

    function int unsigned bump(int unsigned v, int unsigned cap);
      return (v < cap) ? v + 1 : cap;
    endfunction

    function void set_limit(logic [7:0] v);
      near_limit = v;
    endfunction

    function int unsigned pending();
      return expected_stats.size();
    endfunction

    // update the running statistics with one transferred sample
    function void note_sample(sss_pkg::in_item_t item);
      logic signed [7:0]  s;
      int                 v;
      int unsigned        mag;
      int unsigned        idx;
      int unsigned        cap;
      int unsigned        run_last;
      sss_pkg::out_item_t res;
      s = item.sample;
      v = s;
      mag = (v < 0) ? -v : v;
      cap = (sss_pkg::MAX_SAMPLES_DEF < sss_pkg::CNT_MAX) ?
            sss_pkg::MAX_SAMPLES_DEF : sss_pkg::CNT_MAX;
      idx = (seen < sss_pkg::IDX_MAX) ? seen : sss_pkg::IDX_MAX;

      // first sample opens every statistic, later ones extend them
      if (seen == 0) begin
        lo = s;
        hi = s;
        best_val = s;
        best_first = 0;
        best_len = 0;
        run_first = 0;
        run_len = 0;
      end else begin
        if (s < lo) lo = s;
        if (s > hi) hi = s;
        if (s == prev) begin
          run_len = bump(run_len, sss_pkg::IDX_MAX);
          // strictly longer only, so the earliest of equal runs stays
          if (run_len > best_len) begin
            best_len = run_len;
            best_first = run_first;
            best_val = s;
          end
        end else begin
          run_first = idx;
          run_len = 0;
        end
      end

      // saturating tallies
      abs_total = (sss_pkg::SUM_MAX - abs_total >= mag) ? abs_total + mag : sss_pkg::SUM_MAX;
      if (mag <= near_limit) near_tally = bump(near_tally, sss_pkg::CNT_MAX);
      if (s == sss_pkg::CLIP_HI || s == sss_pkg::CLIP_LO) begin
        clip_tally = bump(clip_tally, sss_pkg::CNT_MAX);
      end
      prev = s;
      seen = bump(seen, cap);

      // last sample closes the sequence
      if (item.last) begin
        run_last = best_first + best_len;
        if (run_last > sss_pkg::IDX_MAX) run_last = sss_pkg::IDX_MAX;
        res.min_value = lo;
        res.max_value = hi;
        res.abs_sum = 28'(abs_total);
        res.near_zero_count = 21'(near_tally);
        res.clipped_count = 21'(clip_tally);
        res.sample_total = 21'(seen);
        res.run_value = best_val;
        res.run_start = 20'(best_first);
        res.run_end = 20'(run_last);
        expected_stats.push_back(res);
        restart();
      end
    endfunction

    function void compare_field(string name, logic [27:0] e, logic [27:0] a);
      if (e !== a) begin
        $display("%0t: %s expected 'h%0h, got 'h%0h", $time, name, e, a);
        errors++;
      end
    endfunction

    // compare a result transfer with the oldest expected result
    function void check_stats(sss_pkg::out_item_t got);
      sss_pkg::out_item_t exp;
      if (expected_stats.size() == 0) begin
        $display("%0t: no result expected, got min 'h%0h max 'h%0h total %0d",
                 $time, got.min_value, got.max_value, got.sample_total);
        errors++;
        return;
      end
      exp = expected_stats.pop_front();
      compare_field("min_value", 28'(exp.min_value), 28'(got.min_value));
      compare_field("max_value", 28'(exp.max_value), 28'(got.max_value));
      compare_field("abs_sum", exp.abs_sum, got.abs_sum);
      compare_field("near_zero_count", 28'(exp.near_zero_count), 28'(got.near_zero_count));
      compare_field("clipped_count", 28'(exp.clipped_count), 28'(got.clipped_count));
      compare_field("sample_total", 28'(exp.sample_total), 28'(got.sample_total));
      compare_field("run_value", 28'(exp.run_value), 28'(got.run_value));
      compare_field("run_start", 28'(exp.run_start), 28'(got.run_start));
      compare_field("run_end", 28'(exp.run_end), 28'(got.run_end));
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  sss_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  sss_pkg::out_item_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [7:0]         cfg_data;

  stats_scoreboard sb;
  bit              calm;
  logic [7:0]      cur_limit;

  sample_stream_statistics uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // idle length: mostly none, some short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // observe every transfer on the three channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_limit(cfg_data);
      if (in_valid && in_ready) sb.note_sample(in_data);
      if (out_valid && out_ready) sb.check_stats(out_data);
    end
  end

  // result side stalls
  initial begin
    int unsigned hold;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      hold = idle_len();
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // one sample transfer, with a random gap ahead of it
  task automatic send_sample(input logic signed [7:0] s, input logic l);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{sample: s, last: l};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // a whole sequence with random content, biased toward runs and edge values
  task automatic send_sequence(input int unsigned len);
    logic signed [7:0] s;
    logic signed [7:0] prev_s;
    int unsigned       r;
    prev_s = '0;
    for (int unsigned i = 0; i < len; i++) begin
      r = $urandom_range(0, 9);
      if (i != 0 && r < 4) begin
        s = prev_s;
      end else if (r < 7) begin
        case ($urandom_range(0, 6))
          0: s = sss_pkg::CLIP_HI;
          1: s = sss_pkg::CLIP_LO;
          2: s = 8'sd0;
          3: s = cur_limit;
          4: s = -cur_limit;
          5: s = cur_limit + 8'd1;
          default: s = -(cur_limit + 8'd1);
        endcase
      end else begin
        s = 8'($urandom);
      end
      send_sample(s, i == len - 1);
      prev_s = s;
    end
  endtask

  // let all expected results arrive and the pipeline settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    cur_limit = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // main sequence
  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    logic [7:0]  lim;
    sb = new();
    calm = 1'b0;
    cur_limit = sss_pkg::NEAR_ZERO_RST;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-sample sequences at the extremes and zero
    send_sample(sss_pkg::CLIP_LO, 1'b1);
    send_sample(sss_pkg::CLIP_HI, 1'b1);
    send_sample(8'sd0, 1'b1);
    // near-zero boundary, no repeats
    send_sample(8'sd2, 1'b0);
    send_sample(-8'sd2, 1'b0);
    send_sample(8'sd3, 1'b0);
    send_sample(-8'sd3, 1'b0);
    send_sample(8'sd1, 1'b0);
    send_sample(-8'sd1, 1'b1);
    // two runs of equal length, earliest wins
    send_sample(8'sd5, 1'b0);
    send_sample(8'sd5, 1'b0);
    send_sample(8'sd7, 1'b0);
    send_sample(8'sd7, 1'b0);
    send_sample(-8'sd1, 1'b1);
    // a later, longer run of clipped samples wins
    send_sample(sss_pkg::CLIP_HI, 1'b0);
    send_sample(sss_pkg::CLIP_HI, 1'b0);
    send_sample(sss_pkg::CLIP_LO, 1'b0);
    send_sample(sss_pkg::CLIP_LO, 1'b0);
    send_sample(sss_pkg::CLIP_LO, 1'b0);
    send_sample(8'sd0, 1'b0);
    send_sample(8'sd0, 1'b1);

    // random phases, one limit setting each
    for (int unsigned phase = 0; phase < 8; phase++) begin
      wait_drained();
      case (phase)
        0: lim = 8'd0;
        1: lim = 8'd128;
        2: lim = 8'd255;
        3: lim = 8'd127;
        4: lim = 8'd1;
        7: lim = sss_pkg::NEAR_ZERO_RST;
        default: lim = 8'($urandom);
      endcase
      write_limit(lim);
      calm = (phase == 3);
      sent = 0;
      while (sent < 100) begin
        r = $urandom_range(0, 99);
        if (r < 85) len = $urandom_range(1, 12);
        else if (r < 97) len = $urandom_range(13, 40);
        else len = $urandom_range(41, 150);
        send_sequence(len);
        sent += len;
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
